// ===== hw/rtl/tournament_rank_sorter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Tournament rank sorter - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TOURNAMENT_RANK_SORTER_UNIT_MACROS_SVH
`define TOURNAMENT_RANK_SORTER_UNIT_MACROS_SVH

// same-cycle implication
`define TRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tournament rank sorter: assertion failed");

// next-cycle implication
`define TRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tournament rank sorter: assertion failed");

`endif

// ===== hw/rtl/trs_pkg.sv =====
// ----------------------------------------------------------------------------
// Tournament rank sorter - package
// Field widths, defaults, controller states and chain control struct.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package trs_pkg;

  localparam int DEFAULT_MAX_ROUNDS = 8;
  localparam int DEFAULT_INDEX_BITS = 16;

  localparam int INDEX_W      = 16;
  localparam int FIT_W        = 32;
  localparam int SIZE_W       = 4;
  localparam int RANK_W       = 3;
  localparam int RESULT_LIMIT = 8;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(2);

  typedef enum logic [1:0] {
    ST_COLLECT = 2'b01,
    ST_DRAIN   = 2'b10
  } trs_state_t;

  // per-cycle command to the whole row of cells
  typedef struct packed {
    logic insert;   // sorted insert of the new candidate
    logic shift;    // move every entry one place towards the head
  } chain_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/trs_cell.sv =====
// ----------------------------------------------------------------------------
// Tournament rank sorter - cell
// One ranked slot: compares with the candidate, takes new, left or right data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trs_cell import trs_pkg::*; #(
  parameter int IDX_W = DEFAULT_INDEX_BITS
) (
  input  wire logic                    clk,
  input  wire chain_ctrl_t             ctrl,
  input  wire logic                    live,
  input  wire logic [IDX_W-1:0]        new_idx,
  input  wire logic signed [FIT_W-1:0] new_fit,
  input  wire logic                    left_take,
  input  wire logic [IDX_W-1:0]        left_idx,
  input  wire logic signed [FIT_W-1:0] left_fit,
  input  wire logic [IDX_W-1:0]        right_idx,
  input  wire logic signed [FIT_W-1:0] right_fit,
  output logic                         take,
  output logic [IDX_W-1:0]             idx,
  output logic signed [FIT_W-1:0]      fit
);

  // empty slot, or new candidate ranks at or above this entry
  assign take = !live || (new_fit >= fit);

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (left_take) begin
        idx <= left_idx;
        fit <= left_fit;
      end else if (take) begin
        idx <= new_idx;
        fit <= new_fit;
      end
    end else if (ctrl.shift) begin
      idx <= right_idx;
      fit <= right_fit;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/trs_chain.sv =====
// ----------------------------------------------------------------------------
// Tournament rank sorter - cell chain
// Row of ranked slots, best at the head; insert shifts right, drain left.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trs_chain import trs_pkg::*; #(
  parameter int MAX_ROUNDS = DEFAULT_MAX_ROUNDS,
  parameter int IDX_W      = DEFAULT_INDEX_BITS,
  parameter int CNT_W      = $clog2(DEFAULT_MAX_ROUNDS + 1)
) (
  input  wire logic                    clk,
  input  wire chain_ctrl_t             ctrl,
  input  wire logic [CNT_W-1:0]        live_count,
  input  wire logic [IDX_W-1:0]        new_idx,
  input  wire logic signed [FIT_W-1:0] new_fit,
  output logic [IDX_W-1:0]             head_idx,
  output logic signed [FIT_W-1:0]      head_fit
);

  logic [IDX_W-1:0]        idx  [MAX_ROUNDS];
  logic signed [FIT_W-1:0] fit  [MAX_ROUNDS];
  logic                    take [MAX_ROUNDS];

  for (genvar k = 0; k < MAX_ROUNDS; k++) begin : g_cell
    logic                    l_take;
    logic [IDX_W-1:0]        l_idx;
    logic signed [FIT_W-1:0] l_fit;
    logic [IDX_W-1:0]        r_idx;
    logic signed [FIT_W-1:0] r_fit;

    if (k == 0) begin : g_head
      assign l_take = 1'b0;
      assign l_idx  = new_idx;
      assign l_fit  = new_fit;
    end else begin : g_body
      assign l_take = take[k-1];
      assign l_idx  = idx[k-1];
      assign l_fit  = fit[k-1];
    end

    if (k == MAX_ROUNDS - 1) begin : g_tail
      assign r_idx = idx[k];
      assign r_fit = fit[k];
    end else begin : g_mid
      assign r_idx = idx[k+1];
      assign r_fit = fit[k+1];
    end

    trs_cell #(
      .IDX_W (IDX_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .live      (CNT_W'(k) < live_count),
      .new_idx   (new_idx),
      .new_fit   (new_fit),
      .left_take (l_take),
      .left_idx  (l_idx),
      .left_fit  (l_fit),
      .right_idx (r_idx),
      .right_fit (r_fit),
      .take      (take[k]),
      .idx       (idx[k]),
      .fit       (fit[k])
    );
  end

  assign head_idx = idx[0];
  assign head_fit = fit[0];

endmodule

`default_nettype wire

// ===== hw/rtl/tournament_rank_sorter_unit.sv =====
// ----------------------------------------------------------------------------
// Tournament rank sorter unit
// Sorts tournament candidates by fitness and streams the ranking out.
// ----------------------------------------------------------------------------
// Usage:
//  - Candidate channel (candidate_valid/ready, index and signed fitness):
//    one transaction per cycle while collecting; each candidate is placed
//    into the sorted row of cells in the cycle it is accepted.
//  - When the tournament is complete (bracket_size candidates, 0 treated
//    as 1, capped at MAX_ROUNDS and 8), the ranking streams out on the ranked
//    channel, best first, one transaction per cycle, last_rank on the final.
//  - First result is valid the cycle after the completing candidate; the
//    drain is limited by the single head cell feeding the output.
//  - Candidate input is held off (ready low) while the ranking drains.
//  - If the receiver stalls, the head entry and its rank simply hold.
//  - bracket_size is written via bracket_size_we; the user must write it
//    only while idle, which the block itself does not enforce.
//  - Synchronous reset: empties the store, returns to collecting, restores
//    bracket_size to 2. Slot contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tournament_rank_sorter_unit_macros.svh"

module tournament_rank_sorter_unit import trs_pkg::*; #(
  parameter int MAX_ROUNDS = DEFAULT_MAX_ROUNDS,
  parameter int INDEX_BITS = DEFAULT_INDEX_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // configuration
  input  wire logic                      bracket_size_we,
  input  wire logic [SIZE_W-1:0]         bracket_size_data,
  // candidate channel
  input  wire logic                      candidate_valid,
  output logic                           candidate_ready,
  input  wire logic [INDEX_W-1:0]        candidate_index,
  input  wire logic signed [FIT_W-1:0]   candidate_fitness,
  // ranked channel
  output logic                           ranked_valid,
  input  wire logic                      ranked_ready,
  output logic [INDEX_W-1:0]             ranked_index,
  output logic signed [FIT_W-1:0]        ranked_fitness,
  output logic [RANK_W-1:0]              rank_position,
  output logic                           last_rank
);

  // kept index bits: INDEX_BITS, never more than the port carries
  localparam int SLOT_IDX_W = (INDEX_BITS < INDEX_W) ? INDEX_BITS : INDEX_W;
  localparam int CNT_W      = $clog2(MAX_ROUNDS + 1);
  localparam int CMP_W      = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
  localparam int LIM_CAP    = (MAX_ROUNDS < RESULT_LIMIT) ? MAX_ROUNDS : RESULT_LIMIT;

  trs_state_t        state, state_next;
  logic [SIZE_W-1:0] tsize;
  logic [CNT_W-1:0]  count, count_next;
  logic [RANK_W-1:0] rank_pos, rank_pos_next;
  logic [RANK_W-1:0] last_pos, last_pos_next;

  logic [SIZE_W-1:0]       limit;
  logic [SIZE_W-1:0]       limit_m1;
  logic [CNT_W-1:0]        n_clamped;
  logic [CNT_W-1:0]        n_after;
  logic                    fire;
  logic                    in_fire;
  logic                    out_fire;
  chain_ctrl_t             ctrl;
  logic [SLOT_IDX_W-1:0]   head_idx;

  // effective tournament length
  always_comb begin
    priority if (tsize == '0) begin
      limit = SIZE_W'(1);
    end else if (tsize > SIZE_W'(LIM_CAP)) begin
      limit = SIZE_W'(LIM_CAP);
    end else begin
      limit = tsize;
    end
  end
  assign limit_m1 = limit - SIZE_W'(1);

  // a full row drops its worst entry on the next insert
  assign n_clamped = (count >= CNT_W'(MAX_ROUNDS)) ? CNT_W'(MAX_ROUNDS - 1) : count;
  assign n_after   = n_clamped + CNT_W'(1);
  assign fire      = CMP_W'(n_after) >= CMP_W'(limit);

  assign candidate_ready = (state == ST_COLLECT);
  assign ranked_valid    = (state == ST_DRAIN);
  assign in_fire         = candidate_valid && candidate_ready;
  assign out_fire        = ranked_valid && ranked_ready;

  assign ctrl.insert = in_fire;
  assign ctrl.shift  = out_fire;

  always_comb begin
    state_next    = state;
    count_next    = count;
    rank_pos_next = rank_pos;
    last_pos_next = last_pos;
    unique case (state)
      ST_COLLECT: begin
        if (in_fire) begin
          if (fire) begin
            state_next    = ST_DRAIN;
            count_next    = '0;
            rank_pos_next = '0;
            last_pos_next = limit_m1[RANK_W-1:0];
          end else begin
            count_next = n_after;
          end
        end
      end
      ST_DRAIN: begin
        if (out_fire) begin
          if (rank_pos == last_pos) begin
            state_next = ST_COLLECT;
          end else begin
            rank_pos_next = rank_pos + RANK_W'(1);
          end
        end
      end
      default: begin
        state_next = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_COLLECT;
      count    <= '0;
      tsize    <= SIZE_RESET;
      rank_pos <= '0;
      last_pos <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      rank_pos <= rank_pos_next;
      last_pos <= last_pos_next;
      if (bracket_size_we) begin
        tsize <= bracket_size_data;
      end
    end
  end

  trs_chain #(
    .MAX_ROUNDS (MAX_ROUNDS),
    .IDX_W      (SLOT_IDX_W),
    .CNT_W      (CNT_W)
  ) u_chain (
    .clk        (clk),
    .ctrl       (ctrl),
    .live_count (n_clamped),
    .new_idx    (candidate_index[SLOT_IDX_W-1:0]),
    .new_fit    (candidate_fitness),
    .head_idx   (head_idx),
    .head_fit   (ranked_fitness)
  );

  assign ranked_index  = INDEX_W'(head_idx);
  assign rank_position = rank_pos;
  assign last_rank     = (rank_pos == last_pos);

  // input and output sides never open together
  `TRS_ASSERT_NOW(a_one_side, 1'b1, !(candidate_ready && ranked_valid))
  // completing candidate starts the ranking at the best position
  `TRS_ASSERT_NEXT(a_start_rank, in_fire && fire, ranked_valid && (rank_pos == '0))
  // final result hands control back to collection
  `TRS_ASSERT_NEXT(a_back_collect, out_fire && last_rank, candidate_ready)
  // store is emptied for the next tournament while draining
  `TRS_ASSERT_NOW(a_drain_empty, ranked_valid, count == '0)

endmodule

`default_nettype wire
